>>> sv/joystick_velocity_cmd_yaw_hold_defines.svh
// assertion macros for the joystick velocity command block
// no dependencies; included by the modules that carry assertions
`ifndef JOYSTICK_VELOCITY_CMD_YAW_HOLD_DEFINES_SVH
`define JOYSTICK_VELOCITY_CMD_YAW_HOLD_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is held
`define JVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, live during reset too
`define JVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JVC_ASSERT(lbl, clk, rst_n, prop, msg)
`define JVC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/jvc_pkg.sv
// shared types and constants of the joystick velocity command block
// no dependencies; imported by every module of the block
package jvc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TASK_MODE    = 3'd0;
    localparam logic [2:0] CFG_VEL_MIN      = 3'd1;
    localparam logic [2:0] CFG_VEL_MAX      = 3'd2;
    localparam logic [2:0] CFG_YAW_RATE_MAX = 3'd3;
    localparam logic [2:0] CFG_YAW_GAIN     = 3'd4;

    // walking modes
    localparam logic [3:0] MODE_WALK_A = 4'd3;
    localparam logic [3:0] MODE_WALK_B = 4'd4;

    // reset values
    localparam logic [3:0]         RST_TASK_MODE    = 4'd0;
    localparam logic signed [15:0] RST_VEL_MIN      = -16'sd4096;
    localparam logic [14:0]        RST_VEL_MAX      = 15'd4096;
    localparam logic [14:0]        RST_YAW_RATE_MAX = 15'd4096;
    localparam logic [14:0]        RST_YAW_GAIN     = 15'd0;

    // fixed-point thresholds, Q3.12
    localparam logic signed [16:0] TURN_DEAD  = 17'sd409;
    localparam logic [14:0]        GAIN_MIN   = 15'd41;
    localparam logic signed [16:0] PI_Q       = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q   = 17'sd25736;
    // squared norm of 0.15 in Q3.12, rounded up
    localparam logic [33:0]        MOVE_SQ_MIN = 34'd377488;

    typedef struct packed {
        logic [3:0]         task_mode;
        logic signed [15:0] vel_min;
        logic [14:0]        vel_max;
        logic [14:0]        yaw_rate_max;
        logic [14:0]        yaw_gain;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] axis_lateral;
        logic signed [15:0] axis_forward;
        logic signed [15:0] axis_turn;
        logic signed [15:0] measured_yaw;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] cmd_forward;
        logic signed [15:0] cmd_lateral;
        logic signed [15:0] cmd_yaw_rate;
        logic               heading_held;
    } t_out_item;

    // joystick commands after scaling, before hold and clamping
    typedef struct packed {
        logic signed [16:0] vx_raw;
        logic signed [16:0] vy_raw;
        logic signed [16:0] yr_raw;
        logic signed [15:0] measured_yaw;
    } t_scaled;

endpackage

>>> sv/jvc_scale.sv
// joystick axis scaling: negated axes times the configured ranges
// depends on jvc_pkg
module jvc_scale (
    input  jvc_pkg::t_cfg     i_cfg,
    input  jvc_pkg::t_in_item i_item,
    output jvc_pkg::t_scaled  o_scaled
);
    import jvc_pkg::*;

    logic signed [31:0] p_fwd, p_lat, p_turn;
    logic signed [31:0] q_fwd, q_lat, q_turn;

    // products of the range (Q3.12) and the axis (Q1.15)
    assign p_fwd  = $signed({1'b0, i_cfg.vel_max}) * i_item.axis_forward;
    assign p_lat  = $signed({1'b0, i_cfg.vel_max}) * i_item.axis_lateral;
    assign p_turn = $signed({1'b0, i_cfg.yaw_rate_max}) * i_item.axis_turn;

    // negate, round to nearest with ties up, drop 15 fraction bits
    assign q_fwd  = (-p_fwd + 32'sd16384) >>> 15;
    assign q_lat  = (-p_lat + 32'sd16384) >>> 15;
    assign q_turn = (-p_turn + 32'sd16384) >>> 15;

    assign o_scaled.vx_raw       = q_fwd[16:0];
    assign o_scaled.vy_raw       = q_lat[16:0];
    assign o_scaled.yr_raw       = q_turn[16:0];
    assign o_scaled.measured_yaw = i_item.measured_yaw;

endmodule

>>> sv/jvc_hold.sv
// heading hold, clamping and command history of the joystick command block
// depends on jvc_pkg and joystick_velocity_cmd_yaw_hold_defines.svh
`include "joystick_velocity_cmd_yaw_hold_defines.svh"
module jvc_hold (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  jvc_pkg::t_cfg      i_cfg,
    input  jvc_pkg::t_scaled   i_scaled,
    output jvc_pkg::t_out_item o_result
);
    import jvc_pkg::*;

    logic signed [15:0] r_prev_fwd, r_prev_lat, r_prev_yaw;
    logic signed [15:0] r_held;

    logic               active, op_yaw, gain_low, moving, take_hold;
    logic signed [31:0] sq_fwd, sq_lat, sq_yaw;
    logic [33:0]        sq_sum;
    logic signed [16:0] d_raw, d_wrap;
    logic signed [32:0] g_prod, g_round;
    logic signed [20:0] yr_sel, yr_lo, yr_hi, yr_clamped;
    logic signed [16:0] v_lo, v_hi, vx_a, vx_b, vy_a, vy_b;
    logic               yr_in_range, fwd_in_range, hist_zero;

    // walking modes only
    assign active = (i_cfg.task_mode == MODE_WALK_A) || (i_cfg.task_mode == MODE_WALK_B);

    // operator turn request and hold gain checks
    assign op_yaw   = (i_scaled.yr_raw > TURN_DEAD) || (i_scaled.yr_raw < -TURN_DEAD);
    assign gain_low = i_cfg.yaw_gain < GAIN_MIN;

    // previous command norm against 0.15
    assign sq_fwd = r_prev_fwd * r_prev_fwd;
    assign sq_lat = r_prev_lat * r_prev_lat;
    assign sq_yaw = r_prev_yaw * r_prev_yaw;
    assign sq_sum = {2'b00, sq_fwd} + {2'b00, sq_lat} + {2'b00, sq_yaw};
    assign moving = sq_sum >= MOVE_SQ_MIN;

    assign take_hold = active && !op_yaw && !gain_low && moving;

    // heading error, wrapped once into about plus or minus pi
    assign d_raw = {r_held[15], r_held} - {i_scaled.measured_yaw[15], i_scaled.measured_yaw};
    always_comb begin
        d_wrap = d_raw;
        if (d_raw >= PI_Q) begin
            d_wrap = d_raw - TWO_PI_Q;
        end else if (d_raw <= -PI_Q) begin
            d_wrap = d_raw + TWO_PI_Q;
        end
    end

    // proportional pull, rounded back to Q3.12
    assign g_prod  = $signed({1'b0, i_cfg.yaw_gain}) * d_wrap;
    assign g_round = (g_prod + 33'sd2048) >>> 12;

    // yaw rate select and symmetric clamp
    assign yr_sel = take_hold ? g_round[20:0] : {{4{i_scaled.yr_raw[16]}}, i_scaled.yr_raw};
    assign yr_hi  = $signed({6'b0, i_cfg.yaw_rate_max});
    assign yr_lo  = -yr_hi;
    always_comb begin
        yr_clamped = yr_sel;
        if (yr_sel < yr_lo) begin
            yr_clamped = yr_lo;
        end
        if (yr_clamped > yr_hi) begin
            yr_clamped = yr_hi;
        end
    end

    // velocity clamp: raise to min first, then lower to max
    assign v_lo = {i_cfg.vel_min[15], i_cfg.vel_min};
    assign v_hi = $signed({2'b00, i_cfg.vel_max});
    always_comb begin
        vx_a = (i_scaled.vx_raw < v_lo) ? v_lo : i_scaled.vx_raw;
        vx_b = (vx_a > v_hi) ? v_hi : vx_a;
        vy_a = (i_scaled.vy_raw < v_lo) ? v_lo : i_scaled.vy_raw;
        vy_b = (vy_a > v_hi) ? v_hi : vy_a;
    end

    // result of this request, all zero outside walking modes
    always_comb begin
        o_result = '0;
        if (active) begin
            o_result.cmd_forward  = vx_b[15:0];
            o_result.cmd_lateral  = vy_b[15:0];
            o_result.cmd_yaw_rate = yr_clamped[15:0];
            o_result.heading_held = take_hold;
        end
    end

    // command history and recorded heading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_fwd <= '0;
            r_prev_lat <= '0;
            r_prev_yaw <= '0;
            r_held     <= '0;
        end else if (i_take) begin
            r_prev_fwd <= o_result.cmd_forward;
            r_prev_lat <= o_result.cmd_lateral;
            r_prev_yaw <= o_result.cmd_yaw_rate;
            if (active && !take_hold) begin
                r_held <= i_scaled.measured_yaw;
            end
        end
    end

    // terms for the checks below
    assign yr_in_range  = (o_result.cmd_yaw_rate <= yr_hi) && (o_result.cmd_yaw_rate >= yr_lo);
    assign fwd_in_range = o_result.cmd_forward <= v_hi;
    assign hist_zero    = (r_prev_fwd == '0) && (r_prev_lat == '0) && (r_prev_yaw == '0);

    `JVC_ASSERT(a_yaw_in_clamp, i_clk, i_rst_n, i_take |-> yr_in_range, "yaw rate outside clamp")
    `JVC_ASSERT(a_fwd_below_max, i_clk, i_rst_n, i_take |-> fwd_in_range, "forward above max")
    `JVC_ASSERT(a_idle_clears, i_clk, i_rst_n, i_take && !active |=> hist_zero, "history kept")

endmodule

>>> sv/joystick_velocity_cmd_yaw_hold.sv
// Joystick velocity command generator with proportional heading hold.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) carries three joystick
// axes in Q1.15 and the measured yaw in Q3.12. Output channel (o_out_valid /
// i_out_ready / o_out_item) returns one command per request: forward and
// lateral velocity, yaw rate and a flag set when the yaw rate came from
// heading hold. The user must write registers through i_cfg_we / i_cfg_idx /
// i_cfg_wdata only while no request is in flight; this is not enforced.
// Pipeline: input register, then result register, loaded once it is free;
// one request is taken every cycle while the receiver keeps up. The heading
// hold loop (command history and recorded heading) closes as the result
// registers, so consecutive requests need no gap.
// Reset clears both stages, the command history, the recorded heading and
// loads the default registers. When the receiver stalls, the result waits in
// the output register and the input register still takes one request;
// o_in_ready then drops until the waiting result is taken.
// depends on jvc_pkg, jvc_scale, jvc_hold and the defines header
`include "joystick_velocity_cmd_yaw_hold_defines.svh"
module joystick_velocity_cmd_yaw_hold (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jvc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jvc_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata
);
    import jvc_pkg::*;

    t_cfg      r_cfg;
    logic      r_s1_valid, r_out_valid;
    t_in_item  r_s1_item;
    t_out_item r_out_item;

    t_scaled   s1_scaled;
    t_out_item n_out_item;
    logic      in_acc, out_ld, out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.task_mode    <= RST_TASK_MODE;
            r_cfg.vel_min      <= RST_VEL_MIN;
            r_cfg.vel_max      <= RST_VEL_MAX;
            r_cfg.yaw_rate_max <= RST_YAW_RATE_MAX;
            r_cfg.yaw_gain     <= RST_YAW_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TASK_MODE:    r_cfg.task_mode    <= i_cfg_wdata[3:0];
                CFG_VEL_MIN:      r_cfg.vel_min      <= $signed(i_cfg_wdata);
                CFG_VEL_MAX:      r_cfg.vel_max      <= i_cfg_wdata[14:0];
                CFG_YAW_RATE_MAX: r_cfg.yaw_rate_max <= i_cfg_wdata[14:0];
                CFG_YAW_GAIN:     r_cfg.yaw_gain     <= i_cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // stage advance: each stage loads when the next one is free or moving
    assign out_ld     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || out_ld;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_stall  = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= in_acc || (r_s1_valid && !out_ld);
            r_out_valid <= out_ld || (r_out_valid && !i_out_ready);
        end
    end

    // axis scaling
    jvc_scale u_scale (
        .i_cfg    (r_cfg),
        .i_item   (r_s1_item),
        .o_scaled (s1_scaled)
    );

    // heading hold and clamping, history updated as the result registers
    jvc_hold u_hold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (out_ld),
        .i_cfg    (r_cfg),
        .i_scaled (s1_scaled),
        .o_result (n_out_item)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
        end
        if (out_ld) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `JVC_ASSERT(a_fill_out, i_clk, i_rst_n, r_s1_valid && !r_out_valid |=> r_out_valid, "stuck")
    `JVC_ASSERT(a_ready_on_bubble, i_clk, i_rst_n, !r_s1_valid |-> o_in_ready, "not ready")
    `JVC_ASSERT(a_out_held, i_clk, i_rst_n, out_stall |=> $stable(o_out_item), "result lost")

endmodule

>>> tb/yaw_hold_cmd_checker.sv
// command checker for the joystick velocity block with heading hold
// predicts each command from the observed requests and register writes; uses jvc_pkg
`timescale 1ns / 1ps
module yaw_hold_cmd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  jvc_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  jvc_pkg::t_out_item i_out_item,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    import jvc_pkg::*;

    // fixed-point thresholds, Q3.12
    localparam longint HALF_TURN           = 12868;
    localparam longint FULL_TURN           = 25736;
    localparam longint TURN_DEADBAND       = 409;
    localparam longint HOLD_GAIN_MIN       = 41;
    localparam longint MOVING_NORM_SQ_X100 = 37748736;

    t_cfg      cfg_shadow;
    longint    prev_fwd;
    longint    prev_lat;
    longint    prev_yaw_rate;
    longint    held_heading;
    t_out_item pending_cmds[$];
    int        fail_total = 0;

    assign o_fail_count = fail_total;

    // round to nearest, ties toward plus infinity
    function automatic longint round_half_up(input longint prod, input int shift);
        return (prod + (longint'(1) <<< (shift - 1))) >>> shift;
    endfunction

    // expected command for one request; advances the command history and heading
    function automatic t_out_item predict_velocity_cmd(input t_in_item req);
        longint    lat, fwd, turn, yaw;
        longint    vx, vy, yr, norm_sq, diff;
        longint    vmin, vmax, rmax, gain;
        logic      held;
        t_out_item cmd;
        lat  = req.axis_lateral;
        fwd  = req.axis_forward;
        turn = req.axis_turn;
        yaw  = req.measured_yaw;
        vmin = cfg_shadow.vel_min;
        vmax = cfg_shadow.vel_max;
        rmax = cfg_shadow.yaw_rate_max;
        gain = cfg_shadow.yaw_gain;
        vx = 0;
        vy = 0;
        yr = 0;
        held = 1'b0;
        norm_sq = prev_fwd * prev_fwd + prev_lat * prev_lat + prev_yaw_rate * prev_yaw_rate;
        if (cfg_shadow.task_mode == MODE_WALK_A || cfg_shadow.task_mode == MODE_WALK_B) begin
            vx = round_half_up(-vmax * fwd, 15);
            vy = round_half_up(-vmax * lat, 15);
            yr = round_half_up(-rmax * turn, 15);
            // operator turning, hold disabled or standing still: record heading
            if (yr > TURN_DEADBAND || yr < -TURN_DEADBAND || gain < HOLD_GAIN_MIN
                    || norm_sq * 100 < MOVING_NORM_SQ_X100) begin
                held_heading = yaw;
            end else begin
                diff = held_heading - yaw;
                if (diff >= HALF_TURN) begin
                    diff -= FULL_TURN;
                end else if (diff <= -HALF_TURN) begin
                    diff += FULL_TURN;
                end
                yr = round_half_up(gain * diff, 12);
                held = 1'b1;
            end
            if (yr < -rmax) yr = -rmax;
            if (yr > rmax) yr = rmax;
            // low bound first, so an inverted range ends at vel_max
            if (vx < vmin) vx = vmin;
            if (vx > vmax) vx = vmax;
            if (vy < vmin) vy = vmin;
            if (vy > vmax) vy = vmax;
        end
        prev_fwd = vx;
        prev_lat = vy;
        prev_yaw_rate = yr;
        cmd.cmd_forward  = vx[15:0];
        cmd.cmd_lateral  = vy[15:0];
        cmd.cmd_yaw_rate = yr[15:0];
        cmd.heading_held = held;
        return cmd;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    // register writes, request prediction and command comparison
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item next_cmd;
        if (!i_rst_n) begin
            cfg_shadow.task_mode    = 4'd0;
            cfg_shadow.vel_min      = -16'sd4096;
            cfg_shadow.vel_max      = 15'd4096;
            cfg_shadow.yaw_rate_max = 15'd4096;
            cfg_shadow.yaw_gain     = 15'd0;
            prev_fwd = 0;
            prev_lat = 0;
            prev_yaw_rate = 0;
            held_heading = 0;
            pending_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TASK_MODE:    cfg_shadow.task_mode    = i_cfg_wdata[3:0];
                    CFG_VEL_MIN:      cfg_shadow.vel_min      = i_cfg_wdata;
                    CFG_VEL_MAX:      cfg_shadow.vel_max      = i_cfg_wdata[14:0];
                    CFG_YAW_RATE_MAX: cfg_shadow.yaw_rate_max = i_cfg_wdata[14:0];
                    CFG_YAW_GAIN:     cfg_shadow.yaw_gain     = i_cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_cmds.size() == 0) begin
                    $error("command with no request outstanding: fwd %0d lat %0d yaw %0d",
                           i_out_item.cmd_forward, i_out_item.cmd_lateral,
                           i_out_item.cmd_yaw_rate);
                    fail_total++;
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("cmd_forward", want.cmd_forward, i_out_item.cmd_forward);
                    check_field("cmd_lateral", want.cmd_lateral, i_out_item.cmd_lateral);
                    check_field("cmd_yaw_rate", want.cmd_yaw_rate, i_out_item.cmd_yaw_rate);
                    check_field("heading_held", want.heading_held, i_out_item.heading_held);
                end
            end
            if (i_in_valid && i_in_ready) begin
                next_cmd = predict_velocity_cmd(i_in_item);
                pending_cmds = {pending_cmds, next_cmd};
            end
        end
        o_pending <= pending_cmds.size();
    end

endmodule

>>> tb/tb_joystick_velocity_cmd_yaw_hold.sv
// testbench top for joystick_velocity_cmd_yaw_hold: directed and random requests
// with random stalls on both channels; depends on jvc_pkg and yaw_hold_cmd_checker
`timescale 1ns / 1ps
module tb_joystick_velocity_cmd_yaw_hold;
    import jvc_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [3:0] MODE_OFF     = 4'd0;
    localparam logic [3:0] MODE_LAST    = 4'd15;
    localparam logic [2:0] CFG_IDX_LAST = 3'd7;
    localparam int         YAW_SPAN     = 25736;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = CFG_TASK_MODE;
    logic [15:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          quiet_sender = 1'b0;
    bit          quiet_receiver = 1'b0;
    int          heading_walk = 0;

    joystick_velocity_cmd_yaw_hold uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    yaw_hold_cmd_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_joystick_velocity_cmd_yaw_hold: FAIL");
            $finish;
        end
    end

    // command receiver with a random stall before each result
    initial begin : receiver
        int stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = quiet_receiver ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic t_in_item axes(input int lat, input int fwd, input int turn,
                                      input int yaw);
        t_in_item req;
        req.axis_lateral = 16'(lat);
        req.axis_forward = 16'(fwd);
        req.axis_turn    = 16'(turn);
        req.measured_yaw = 16'(yaw);
        return req;
    endfunction

    function automatic logic [15:0] pick_axis_extreme();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'hFFFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // random request: mostly a drifting heading with a quiet turn stick
    function automatic t_in_item draw_request();
        t_in_item req;
        int yaw;
        case ($urandom_range(0, 9))
            0, 1: begin
                yaw = int'($urandom_range(0, 2 * YAW_SPAN)) - YAW_SPAN;
                req = axes($urandom, $urandom, $urandom, yaw);
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: yaw = -YAW_SPAN;
                    1: yaw = YAW_SPAN;
                    2: yaw = YAW_SPAN / 2;
                    3: yaw = -YAW_SPAN / 2;
                    default: yaw = 0;
                endcase
                req = axes(pick_axis_extreme(), pick_axis_extreme(), pick_axis_extreme(), yaw);
            end
            default: begin
                if ($urandom_range(0, 19) == 0) begin
                    heading_walk = int'($urandom_range(0, 2 * YAW_SPAN)) - YAW_SPAN;
                end else begin
                    heading_walk += int'($urandom_range(0, 1600)) - 800;
                    if (heading_walk > YAW_SPAN) heading_walk -= 2 * YAW_SPAN;
                    if (heading_walk < -YAW_SPAN) heading_walk += 2 * YAW_SPAN;
                end
                case ($urandom_range(0, 3))
                    0, 1: yaw = 0;
                    2: yaw = int'($urandom_range(0, 8000)) - 4000;
                    default: yaw = $urandom;
                endcase
                req = axes($urandom, $urandom, yaw, heading_walk);
            end
        endcase
        return req;
    endfunction

    // offer one request after a random gap and hold it until taken
    task automatic send_request(input t_in_item req);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    // let every outstanding request come back before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] mode, input logic [15:0] vmin,
                              input logic [15:0] vmax, input logic [15:0] rmax,
                              input logic [15:0] gain);
        write_reg(CFG_TASK_MODE, {12'($urandom), mode});
        write_reg(CFG_VEL_MIN, vmin);
        write_reg(CFG_VEL_MAX, vmax);
        write_reg(CFG_YAW_RATE_MAX, rmax);
        write_reg(CFG_YAW_GAIN, gain);
        // unmapped index must be ignored
        write_reg(3'($urandom_range(CFG_YAW_GAIN + 1, CFG_IDX_LAST)), 16'($urandom));
    endtask

    // 15-bit limit with a random junk top bit
    function automatic logic [15:0] draw_limit_word();
        logic [14:0] lim;
        case ($urandom_range(0, 4))
            0: lim = 15'd0;
            1: lim = 15'h7FFF;
            2: lim = 15'($urandom_range(0, 100));
            3: lim = 15'd4096;
            default: lim = 15'($urandom);
        endcase
        return {1'($urandom), lim};
    endfunction

    task automatic random_config();
        logic [3:0]  mode;
        logic [15:0] vmin;
        logic [15:0] gain;
        if ($urandom_range(0, 4) != 0) begin
            mode = $urandom_range(0, 1) ? MODE_WALK_A : MODE_WALK_B;
        end else begin
            mode = 4'($urandom);
        end
        case ($urandom_range(0, 5))
            0: vmin = 16'h8000;
            1: vmin = 16'h0000;
            2: vmin = -16'sd4096;
            3: vmin = 16'($urandom);
            default: vmin = -16'($urandom_range(0, 32768));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            gain = 16'(40 + $urandom_range(0, 1));
        end else begin
            gain = draw_limit_word();
        end
        set_config(mode, vmin, draw_limit_word(), draw_limit_word(), gain);
    endtask

    initial begin : stimulus
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // moving threshold, dead band edges and heading wrap
        set_config(MODE_WALK_A, -16'sd4096, 16'd4096, 16'd4096, 16'd4096);
        send_request(axes(0, -4912, 0, 0));
        send_request(axes(0, -4912, 0, 500));
        send_request(axes(0, -4920, 0, 1000));
        send_request(axes(0, -4920, 0, 2000));
        send_request(axes(32767, -4920, 32767, 12000));
        send_request(axes(-32768, -4920, 0, -868));
        send_request(axes(0, -4920, 0, 868));
        send_request(axes(0, -4920, -32768, YAW_SPAN));
        send_request(axes(0, -4920, 0, -YAW_SPAN));
        send_request(axes(0, -4920, 32767, -YAW_SPAN));
        send_request(axes(0, -4920, 0, YAW_SPAN));
        send_request(axes(0, -32768, 0, -12868));
        send_request(axes(0, 32767, -3272, 0));
        send_request(axes(0, -4912, -3280, 0));
        wait_idle();

        // hold gain just below and at its minimum
        set_config(MODE_WALK_B, -16'sd4096, 16'd4096, 16'd4096, 16'd40);
        send_request(axes(0, -32768, 0, 0));
        send_request(axes(0, -32768, 0, 3000));
        wait_idle();
        write_reg(CFG_YAW_GAIN, 16'd41);
        send_request(axes(0, -32768, 0, 0));
        send_request(axes(0, -32768, 0, 3000));
        wait_idle();

        // non-walking modes give zeros and keep the heading
        write_reg(CFG_TASK_MODE, {12'd0, MODE_LAST});
        send_request(axes(32767, 32767, 32767, YAW_SPAN));
        wait_idle();
        write_reg(CFG_TASK_MODE, {12'd0, MODE_OFF});
        send_request(axes(-32768, -32768, -32768, -YAW_SPAN));
        wait_idle();

        // inverted velocity range
        set_config(MODE_WALK_A, 16'sd8192, 16'd4096, 16'd4096, 16'd4096);
        send_request(axes(0, 0, 0, 0));
        send_request(axes(-32768, 32767, 0, 100));

        // random phases, the first two at the register extremes
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            case (phase)
                0: set_config(MODE_WALK_B, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                1: set_config(MODE_WALK_A, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                default: random_config();
            endcase
            for (n = 0; n < 100; n++) begin
                if (n % 25 == 0) begin
                    quiet_sender   = ($urandom_range(0, 3) == 0);
                    quiet_receiver = ($urandom_range(0, 3) == 0);
                end
                send_request(draw_request());
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_joystick_velocity_cmd_yaw_hold: PASS");
        end else begin
            $display("tb_joystick_velocity_cmd_yaw_hold: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/jvc_pkg.sv
sv/jvc_scale.sv
sv/jvc_hold.sv
sv/joystick_velocity_cmd_yaw_hold.sv
tb/yaw_hold_cmd_checker.sv
tb/tb_joystick_velocity_cmd_yaw_hold.sv
